[rtl/modbus_rtu_master_framer_assert.svh]
// Assertion macros used by the Modbus RTU master framer RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef MODBUS_RTU_MASTER_FRAMER_ASSERT_SVH
`define MODBUS_RTU_MASTER_FRAMER_ASSERT_SVH
// Check a property on every rising clock edge outside reset.
`define MRF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("framer assertion failed");
// Check that a condition never holds outside reset.
`define MRF_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("framer forbidden condition seen");
`endif

[rtl/mrf_pkg.sv]
// Package for the Modbus RTU master framer: types, codes, CRC helper.
// No dependencies.
package mrf_pkg;

  localparam int BUFFER_BYTES = 256;
  localparam int LEN_W = $clog2(BUFFER_BYTES + 1);

  typedef enum logic [1:0] {
    MODE_READ    = 2'd0,
    MODE_WRITE   = 2'd1,
    MODE_PAYLOAD = 2'd2,
    MODE_RX      = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    RT_COIL     = 2'd0,
    RT_DISCRETE = 2'd1,
    RT_HOLDING  = 2'd2,
    RT_INPUT    = 2'd3
  } reg_type_e;

  typedef enum logic [2:0] {
    ST_PENDING     = 3'd0,
    ST_OK          = 3'd1,
    ST_INVALID     = 3'd2,
    ST_UNSUPPORTED = 3'd3,
    ST_TOO_LONG    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CMD_STATUS,
    CMD_READ,
    CMD_WSINGLE,
    CMD_WMULTI,
    CMD_PAYLOAD,
    CMD_RX
  } cmd_kind_e;

  localparam logic [7:0] FC_WRITE_COIL       = 8'h05;
  localparam logic [7:0] FC_WRITE_REG        = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTI_COIL = 8'h0F;
  localparam logic [7:0] FC_WRITE_MULTI_REG  = 8'h10;
  localparam logic [15:0] CRC_INIT           = 16'hFFFF;
  localparam logic [15:0] CRC_POLY           = 16'hA001;

  typedef struct packed {
    cmd_kind_e         kind;
    status_e           status;
    logic [7:0]        dev;
    logic [7:0]        func;
    logic [15:0]       addr;
    logic [15:0]       cnt;
    logic [7:0]        bcnt;
    logic [7:0]        data;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  dlen;
  } cmd_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/mrf_front.sv]
// Front end: classify an input item into a framer command.
// Depends on mrf_pkg.
module mrf_front import mrf_pkg::*; (
  input  logic [1:0]  mode_i,
  input  logic [1:0]  reg_type_i,
  input  logic [7:0]  device_addr_i,
  input  logic [15:0] reg_addr_i,
  input  logic [15:0] count_or_value_i,
  input  logic        is_single_i,
  input  logic [7:0]  data_byte_i,
  output cmd_t        cmd_o
);

  logic [16:0] dlen;
  logic [17:0] read_len;
  logic [17:0] multi_len;
  logic        bit_type;

  always_comb begin
    bit_type  = (reg_type_i == RT_COIL) || (reg_type_i == RT_DISCRETE);
    dlen      = bit_type ? 17'((18'(count_or_value_i) + 18'd7) >> 3)
                         : {count_or_value_i, 1'b0};
    read_len  = 18'd5 + 18'(dlen);
    multi_len = 18'd9 + 18'(dlen);

    cmd_o        = '0;
    cmd_o.dev    = device_addr_i;
    cmd_o.addr   = reg_addr_i;
    cmd_o.cnt    = count_or_value_i;
    cmd_o.bcnt   = dlen[7:0];
    cmd_o.data   = data_byte_i;
    cmd_o.dlen   = dlen[LEN_W-1:0];
    cmd_o.status = ST_PENDING;
    case (mode_e'(mode_i))
      MODE_READ: begin
        if (read_len > 18'(BUFFER_BYTES)) begin
          cmd_o.kind   = CMD_STATUS;
          cmd_o.status = ST_TOO_LONG;
        end else begin
          cmd_o.kind = CMD_READ;
          cmd_o.func = 8'(reg_type_i) + 8'd1;
          cmd_o.len  = read_len[LEN_W-1:0];
        end
      end
      MODE_WRITE: begin
        cmd_o.len = LEN_W'(8);
        if (!bit_type ? (reg_type_i == RT_INPUT) : (reg_type_i == RT_DISCRETE)) begin
          cmd_o.kind   = CMD_STATUS;
          cmd_o.status = ST_UNSUPPORTED;
        end else if (is_single_i) begin
          cmd_o.kind = CMD_WSINGLE;
          cmd_o.func = (reg_type_i == RT_COIL) ? FC_WRITE_COIL : FC_WRITE_REG;
        end else if (dlen == '0) begin
          cmd_o.kind   = CMD_STATUS;
          cmd_o.status = ST_INVALID;
        end else if (multi_len > 18'(BUFFER_BYTES)) begin
          cmd_o.kind   = CMD_STATUS;
          cmd_o.status = ST_TOO_LONG;
        end else begin
          cmd_o.kind = CMD_WMULTI;
          cmd_o.func = (reg_type_i == RT_COIL) ? FC_WRITE_MULTI_COIL : FC_WRITE_MULTI_REG;
        end
      end
      MODE_PAYLOAD: cmd_o.kind = CMD_PAYLOAD;
      MODE_RX:      cmd_o.kind = CMD_RX;
      default:      cmd_o.kind = CMD_RX;
    endcase
  end

endmodule

[rtl/mrf_cmd_fifo.sv]
// Two-entry command queue between the front end and the sequencer.
// Depends on mrf_pkg.
module mrf_cmd_fifo import mrf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  cmd_t       mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

[rtl/mrf_back.sv]
// Back end: run queued commands, keep framer state, drive the result register.
// Depends on mrf_pkg and modbus_rtu_master_framer_assert.svh.
`include "modbus_rtu_master_framer_assert.svh"
module mrf_back import mrf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] tx_byte_o,
  output logic       tx_valid_o,
  output logic [7:0] rx_data_o,
  output logic       rx_data_valid_o,
  output logic [2:0] status_o,
  output logic       last_o
);

  logic [7:0]       expect_addr_q, expect_addr_d;
  logic [7:0]       expect_func_q, expect_func_d;
  logic [LEN_W-1:0] resp_length_q, resp_length_d;
  logic [LEN_W-1:0] resp_data_len_q, resp_data_len_d;
  logic [LEN_W-1:0] rx_position_q, rx_position_d;
  logic [LEN_W-1:0] payload_left_q, payload_left_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       crc_low_q, crc_low_d;
  logic             hdr_match_q, hdr_match_d;
  logic [2:0]       step_q, step_d;

  logic             out_valid_q;
  logic [7:0]       tx_byte_q, rx_data_q;
  logic             tx_valid_q, rx_valid_q, last_q;
  status_e          status_q;

  logic       emit, fin, slot, adv;
  logic [7:0] r_tx, r_rx, hb;
  logic       r_txv, r_rxv, r_last;
  status_e    r_st;
  logic [LEN_W:0] pos_p2;
  logic [15:0]    got;

  assign slot = !out_valid_q || out_ready_i;
  assign adv  = cmd_valid_i && (emit ? slot : fin);
  assign cmd_pop_o = adv && fin;

  always_comb begin
    case (step_q)
      3'd0:    hb = cmd_i.dev;
      3'd1:    hb = cmd_i.func;
      3'd2:    hb = cmd_i.addr[15:8];
      3'd3:    hb = cmd_i.addr[7:0];
      3'd4:    hb = cmd_i.cnt[15:8];
      3'd5:    hb = cmd_i.cnt[7:0];
      default: hb = cmd_i.bcnt;
    endcase
  end

  always_comb begin
    expect_addr_d   = expect_addr_q;
    expect_func_d   = expect_func_q;
    resp_length_d   = resp_length_q;
    resp_data_len_d = resp_data_len_q;
    rx_position_d   = rx_position_q;
    payload_left_d  = payload_left_q;
    crc_d           = crc_q;
    crc_low_d       = crc_low_q;
    hdr_match_d     = hdr_match_q;
    emit   = 1'b0;
    fin    = 1'b0;
    r_tx   = 8'h00;
    r_txv  = 1'b0;
    r_rx   = 8'h00;
    r_rxv  = 1'b0;
    r_st   = ST_PENDING;
    r_last = 1'b0;
    pos_p2 = {1'b0, rx_position_q} + (LEN_W+1)'(2);
    got    = {cmd_i.data, crc_low_q};
    case (cmd_i.kind)
      CMD_STATUS: begin
        emit = 1'b1;
        fin  = 1'b1;
        r_st = cmd_i.status;
        r_last         = 1'b1;
        resp_length_d  = '0;
        payload_left_d = '0;
        rx_position_d  = '0;
        crc_d          = CRC_INIT;
      end
      CMD_READ, CMD_WSINGLE, CMD_WMULTI: begin
        emit  = 1'b1;
        r_txv = 1'b1;
        if (step_q < 3'd6 || (cmd_i.kind == CMD_WMULTI)) begin
          r_tx  = hb;
          crc_d = crc_feed((step_q == 3'd0) ? CRC_INIT : crc_q, hb);
        end else if (step_q == 3'd6) begin
          r_tx = crc_q[7:0];
        end else begin
          r_tx  = crc_q[15:8];
          crc_d = CRC_INIT;
        end
        if ((cmd_i.kind == CMD_WMULTI) ? (step_q == 3'd6) : (step_q == 3'd7)) begin
          fin             = 1'b1;
          r_last          = 1'b1;
          payload_left_d  = (cmd_i.kind == CMD_WMULTI) ? cmd_i.dlen : '0;
          expect_addr_d   = cmd_i.dev;
          expect_func_d   = cmd_i.func;
          resp_length_d   = cmd_i.len;
          resp_data_len_d = (cmd_i.kind == CMD_READ) ? cmd_i.dlen : '0;
          rx_position_d   = '0;
          hdr_match_d     = 1'b1;
          crc_low_d       = 8'h00;
        end
      end
      CMD_PAYLOAD: begin
        if (step_q == 3'd0) begin
          if (payload_left_q == '0) begin
            fin = 1'b1;
          end else begin
            emit  = 1'b1;
            r_txv = 1'b1;
            r_tx  = cmd_i.data;
            crc_d = crc_feed(crc_q, cmd_i.data);
            payload_left_d = payload_left_q - LEN_W'(1);
            if (payload_left_q != LEN_W'(1)) begin
              fin    = 1'b1;
              r_last = 1'b1;
            end
          end
        end else if (step_q == 3'd1) begin
          emit  = 1'b1;
          r_txv = 1'b1;
          r_tx  = crc_q[7:0];
        end else begin
          emit   = 1'b1;
          r_txv  = 1'b1;
          r_tx   = crc_q[15:8];
          crc_d  = CRC_INIT;
          fin    = 1'b1;
          r_last = 1'b1;
        end
      end
      CMD_RX: begin
        fin = 1'b1;
        if (payload_left_q == '0 && resp_length_q != '0 &&
            rx_position_q < resp_length_q) begin
          emit   = 1'b1;
          r_last = 1'b1;
          rx_position_d = rx_position_q + LEN_W'(1);
          if (pos_p2 < {1'b0, resp_length_q}) begin
            crc_d = crc_feed(crc_q, cmd_i.data);
            if (rx_position_q == '0 && cmd_i.data != expect_addr_q) begin
              hdr_match_d = 1'b0;
            end
            if (rx_position_q == LEN_W'(1) && cmd_i.data != expect_func_q) begin
              hdr_match_d = 1'b0;
            end
            if (rx_position_q >= LEN_W'(3) &&
                {1'b0, rx_position_q} < ({1'b0, resp_data_len_q} + (LEN_W+1)'(3))) begin
              r_rxv = 1'b1;
              r_rx  = cmd_i.data;
            end
          end else if (pos_p2 == {1'b0, resp_length_q}) begin
            crc_low_d = cmd_i.data;
          end else begin
            r_st = (hdr_match_q && got == crc_q) ? ST_OK : ST_INVALID;
            // drop back to idle once the frame is judged
            resp_length_d  = '0;
            payload_left_d = '0;
            rx_position_d  = '0;
            crc_d          = CRC_INIT;
          end
        end
      end
      default: fin = 1'b1;
    endcase
    step_d = fin ? 3'd0 : step_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_addr_q   <= 8'h00;
      expect_func_q   <= 8'h00;
      resp_length_q   <= '0;
      resp_data_len_q <= '0;
      rx_position_q   <= '0;
      payload_left_q  <= '0;
      crc_q           <= CRC_INIT;
      crc_low_q       <= 8'h00;
      hdr_match_q     <= 1'b1;
      step_q          <= 3'd0;
      out_valid_q     <= 1'b0;
    end else begin
      if (adv) begin
        expect_addr_q   <= expect_addr_d;
        expect_func_q   <= expect_func_d;
        resp_length_q   <= resp_length_d;
        resp_data_len_q <= resp_data_len_d;
        rx_position_q   <= rx_position_d;
        payload_left_q  <= payload_left_d;
        crc_q           <= crc_d;
        crc_low_q       <= crc_low_d;
        hdr_match_q     <= hdr_match_d;
        step_q          <= step_d;
      end
      if (adv && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      tx_byte_q  <= r_tx;
      tx_valid_q <= r_txv;
      rx_data_q  <= r_rx;
      rx_valid_q <= r_rxv;
      status_q   <= r_st;
      last_q     <= r_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign tx_byte_o       = tx_byte_q;
  assign tx_valid_o      = tx_valid_q;
  assign rx_data_o       = rx_data_q;
  assign rx_data_valid_o = rx_valid_q;
  assign status_o        = status_q;
  assign last_o          = last_q;

  `MRF_ASSERT_NEVER(a_tx_rx_excl, out_valid_q && tx_valid_q && rx_valid_q)
  `MRF_ASSERT(a_status_last, (out_valid_q && status_q != ST_PENDING) |-> last_q)
  `MRF_ASSERT(a_payload_armed, (payload_left_q != '0) |-> (resp_length_q == LEN_W'(8)))
  `MRF_ASSERT(a_step_bound, (step_q != 3'd0) |-> cmd_valid_i)

endmodule

[rtl/modbus_rtu_master_framer.sv]
// Top level of the Modbus RTU master framer.
// Depends on mrf_pkg, mrf_front, mrf_cmd_fifo and mrf_back.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one beat per item: a read
//   request, a write request, a multi-write payload byte or a received
//   response byte, selected by mode_i.
//   Output channel (out_valid_o/out_ready_i) delivers result beats: request
//   frame bytes on tx_byte_o, response data on rx_data_o, a final status on
//   status_o; last_o marks the final beat caused by one input beat.
//   Items that cause no result (stray payload or received bytes) are dropped.
// Timing:
//   A beat is classified and stored in a two-entry command queue; with the
//   queue empty, the first result beat is offered once the command has
//   passed the queue and the result register. The sequencer emits one result
//   beat per cycle while the result register is free or being read: a request
//   gives 7 to 8 beats (one per frame byte), a payload byte 1 or 3, a received
//   byte or an error status 1, and a dropped item none. Input is taken while
//   the queue has room, also while a result waits.
// Reset:
//   Clears the queue, the output valid flag and the receive state; the CRC
//   starts at all ones and the receiver is idle.
// Stall:
//   When out_ready_i is low the result register holds, the sequencer stops,
//   and the queue fills; in_ready_o falls once both entries are taken.
module modbus_rtu_master_framer import mrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [1:0]  reg_type_i,
  input  logic [7:0]  device_addr_i,
  input  logic [15:0] reg_addr_i,
  input  logic [15:0] count_or_value_i,
  input  logic        is_single_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  tx_byte_o,
  output logic        tx_valid_o,
  output logic [7:0]  rx_data_o,
  output logic        rx_data_valid_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  cmd_t new_cmd, head_cmd;
  logic full, head_valid, pop;

  // classify the incoming beat
  mrf_front u_front (
    .mode_i           (mode_i),
    .reg_type_i       (reg_type_i),
    .device_addr_i    (device_addr_i),
    .reg_addr_i       (reg_addr_i),
    .count_or_value_i (count_or_value_i),
    .is_single_i      (is_single_i),
    .data_byte_i      (data_byte_i),
    .cmd_o            (new_cmd)
  );

  assign in_ready_o = !full;

  // hold classified commands until the sequencer takes them
  mrf_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i && !full),
    .push_cmd_i (new_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (head_valid),
    .head_o     (head_cmd)
  );

  // advance commands one result beat per cycle while the output can take it
  mrf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (head_valid),
    .cmd_i           (head_cmd),
    .cmd_pop_o       (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .tx_byte_o       (tx_byte_o),
    .tx_valid_o      (tx_valid_o),
    .rx_data_o       (rx_data_o),
    .rx_data_valid_o (rx_data_valid_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

endmodule
